>>> rtl/core/spatial_hash_point_dedup_defines.svh
// Assertion helpers for the point dedup block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SPATIAL_HASH_POINT_DEDUP_DEFINES_SVH
`define SPATIAL_HASH_POINT_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SHPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define SHPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/shpd_pkg.sv
package shpd_pkg;

    // Fixed field widths
    localparam int COORD_W = 20;
    localparam int DIST_W  = 16;
    localparam int CNT_W   = 5;
    localparam int SPAN_W  = 24;
    localparam int STAT_W  = 3;
    localparam int PADDR_W = 5;
    localparam int IDX_W   = 3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_MATCH     = 3'd4;
    localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd5;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_NEIGHBOR_MIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXACT_MIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_QUERY_RADIUS = 3'd2;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0]        neighbor_min_distance;
        logic [DIST_W-1:0]        exact_min_distance;
        logic [DIST_W-1:0]        query_radius;
        logic signed [DIST_W-1:0] origin_cell_x;
        logic signed [DIST_W-1:0] origin_cell_y;
    } cfg_t;

endpackage

>>> rtl/core/shpd_if.sv
interface shpd_in_if
    import shpd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      check_neighbors;

    modport source (output valid, command, pos_x, pos_y, check_neighbors, input ready);
    modport sink   (input valid, command, pos_x, pos_y, check_neighbors, output ready);
endinterface

interface shpd_out_if
    import shpd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [COORD_W-1:0] match_x;
    logic signed [COORD_W-1:0] match_y;
    logic                      last;
    logic                      truncated;

    modport source (output valid, status, match_x, match_y, last, truncated, input ready);
    modport sink   (input valid, status, match_x, match_y, last, truncated, output ready);
endinterface

>>> rtl/core/shpd_cfg.sv
module shpd_cfg
    import shpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t             cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neighbor_min_distance <= 16'd128;
            cfg_reg.exact_min_distance    <= 16'd26;
            cfg_reg.query_radius          <= 16'd512;
            cfg_reg.origin_cell_x         <= '0;
            cfg_reg.origin_cell_y         <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_NEIGHBOR_MIN: cfg_reg.neighbor_min_distance <= pwdata[15:0];
                REG_EXACT_MIN:    cfg_reg.exact_min_distance    <= pwdata[15:0];
                REG_QUERY_RADIUS: cfg_reg.query_radius          <= pwdata[15:0];
                REG_ORIGIN_X:     cfg_reg.origin_cell_x         <= $signed(pwdata[15:0]);
                REG_ORIGIN_Y:     cfg_reg.origin_cell_y         <= $signed(pwdata[15:0]);
                default:          ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_NEIGHBOR_MIN: prdata = {16'd0, cfg_reg.neighbor_min_distance};
            REG_EXACT_MIN:    prdata = {16'd0, cfg_reg.exact_min_distance};
            REG_QUERY_RADIUS: prdata = {16'd0, cfg_reg.query_radius};
            REG_ORIGIN_X:     prdata = {{16{cfg_reg.origin_cell_x[15]}}, cfg_reg.origin_cell_x};
            REG_ORIGIN_Y:     prdata = {{16{cfg_reg.origin_cell_y[15]}}, cfg_reg.origin_cell_y};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/shpd_store.sv
module shpd_store
    import shpd_pkg::*;
#(
    parameter int NCELLS  = 4096,
    parameter int NSLOTS  = 81920,
    parameter int CELL_AW = 12,
    parameter int SLOT_AW = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 clr_busy,
    input  logic                 cnt_rd_en,
    input  logic [CELL_AW-1:0]   cnt_rd_addr,
    output logic [CNT_W-1:0]     cnt_rdata,
    input  logic                 cnt_we,
    input  logic [CELL_AW-1:0]   cnt_wr_addr,
    input  logic [CNT_W-1:0]     cnt_wdata,
    input  logic                 slot_rd_en,
    input  logic [SLOT_AW-1:0]   slot_rd_addr,
    output logic [2*COORD_W-1:0] slot_rdata,
    input  logic                 slot_we,
    input  logic [SLOT_AW-1:0]   slot_wr_addr,
    input  logic [2*COORD_W-1:0] slot_wdata
);

    logic [CNT_W-1:0]     cnt_mem [NCELLS];
    logic [2*COORD_W-1:0] slot_mem [NSLOTS];

    logic [CNT_W-1:0]     cnt_rdata_reg;
    logic [2*COORD_W-1:0] slot_rdata_reg;
    logic                 clr_busy_reg;
    logic [CELL_AW-1:0]   clr_idx_reg;

    logic                 cw_en;
    logic [CELL_AW-1:0]   cw_addr;
    logic [CNT_W-1:0]     cw_data;

    assign clr_busy   = clr_busy_reg;
    assign cnt_rdata  = cnt_rdata_reg;
    assign slot_rdata = slot_rdata_reg;

    // Sweep the count memory to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == CELL_AW'(NCELLS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign cw_en   = clr_busy_reg || cnt_we;
    assign cw_addr = clr_busy_reg ? clr_idx_reg : cnt_wr_addr;
    assign cw_data = clr_busy_reg ? '0 : cnt_wdata;

    // Count memory
    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cnt_mem[cw_addr] <= cw_data;
        end
        if (cnt_rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_rd_addr];
        end
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= slot_wdata;
        end
        if (slot_rd_en)
        begin
            slot_rdata_reg <= slot_mem[slot_rd_addr];
        end
    end

endmodule

>>> rtl/core/shpd_dist.sv
module shpd_dist
    import shpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] slot_x,
    input  logic signed [COORD_W-1:0] slot_y,
    input  logic [DIST_W-1:0]         thr,
    output logic                      hit
);

    localparam int D_W  = COORD_W + 1;
    localparam int SQ_W = 2 * D_W;

    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [2*DIST_W-1:0]    thr2_reg;
    logic [SQ_W:0]          sum;

    assign dx = D_W'(pos_x) - D_W'(slot_x);
    assign dy = D_W'(pos_y) - D_W'(slot_y);

    // Square the offsets and the threshold
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sqx_reg  <= SQ_W'(dx * dx);
            sqy_reg  <= SQ_W'(dy * dy);
            thr2_reg <= thr * thr;
        end
    end

    // Compare the squared distance
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit = sum < (SQ_W + 1)'(thr2_reg);

endmodule

>>> rtl/core/spatial_hash_point_dedup.sv
// Point dedup store over a uniform grid of cells.
// in_ch carries one command per transaction: insert (command 0) or radius
// query (command 1) at pos_x/pos_y. out_ch returns the results: an insert
// gives one transaction with last set; a query gives one transaction per
// stored point inside the radius (up to MAX_MATCHES, truncated set on the
// final one when more existed), or one "no match" transaction.
// Registers must be written over the APB-style port only while idle;
// the user keeps to this, the block does not enforce it. Each scanned
// cell passes S_CELL, S_CNT, S_NEXT (count read and advance), each stored
// slot in it S_RD, S_MUL, S_CMP (slot read, square, compare), and each
// command also passes S_GRID and S_SETUP and ends in S_RESULT. An own-cell
// insert scans its own cell only, a neighbor insert up to 9 cells; a query
// scans (2*ceil(radius/cell)+1)^2 cells, clipped to the grid. One command
// at a time, paced by the single read port of the slot memory. After reset
// the cell counts are swept to zero; in_ch.ready stays low meanwhile. When
// out_ch stalls, the scan holds at the next match and no slot is skipped.
`include "spatial_hash_point_dedup_defines.svh"

module spatial_hash_point_dedup
    import shpd_pkg::*;
#(
    parameter int GRID_W      = 64,
    parameter int GRID_H      = 64,
    parameter int CELL_SLOTS  = 20,
    parameter int CELL_SHIFT  = 9,
    parameter int MAX_MATCHES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    shpd_in_if.sink            in_ch,
    shpd_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NCELLS  = GRID_W * GRID_H;
    localparam int NSLOTS  = NCELLS * CELL_SLOTS;
    localparam int CELL_AW = $clog2(NCELLS);
    localparam int SLOT_AW = $clog2(NSLOTS);
    localparam int GX_W    = $clog2(GRID_W);
    localparam int GY_W    = $clog2(GRID_H);
    localparam int N_W     = $clog2(MAX_MATCHES + 1);
    localparam logic [DIST_W:0] CELL_ROUND = (DIST_W + 1)'((1 << CELL_SHIFT) - 1);
    localparam logic signed [SPAN_W-1:0] X_MAX = SPAN_W'(GRID_W - 1);
    localparam logic signed [SPAN_W-1:0] Y_MAX = SPAN_W'(GRID_H - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GRID   = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_CELL   = 4'd3;
    localparam logic [3:0] S_CNT    = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;
    localparam logic [3:0] S_RESULT = 4'd10;

    cfg_t cfg;
    logic clr_busy;

    // Item and scan state
    logic [3:0]                state_reg, state_next;
    logic                      cmd_reg, cmd_next;
    logic                      nb_reg, nb_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [SPAN_W-1:0]  gx_reg, gx_next;
    logic signed [SPAN_W-1:0]  gy_reg, gy_next;
    logic [GX_W-1:0]           x_lo_reg, x_lo_next, x_hi_reg, x_hi_next, cx_reg, cx_next;
    logic [GY_W-1:0]           y_lo_reg, y_lo_next, y_hi_reg, y_hi_next, cy_reg, cy_next;
    logic [DIST_W-1:0]         thr_reg, thr_next;
    logic [CELL_AW-1:0]        own_cell_reg, own_cell_next;
    logic [CELL_AW-1:0]        cell_addr_reg, cell_addr_next;
    logic [SLOT_AW-1:0]        base_reg, base_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          s_reg, s_next;
    logic [CNT_W-1:0]          own_cnt_reg, own_cnt_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic                      trunc_reg, trunc_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic signed [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic signed [COORD_W-1:0] pend_y_reg, pend_y_next;
    logic [STAT_W-1:0]         res_status_reg, res_status_next;
    logic signed [COORD_W-1:0] res_x_reg, res_x_next;
    logic signed [COORD_W-1:0] res_y_reg, res_y_next;
    logic                      res_trunc_reg, res_trunc_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]         out_status_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic                      out_last_reg;
    logic                      out_trunc_reg;
    logic                      out_free;
    logic                      out_load;
    logic [STAT_W-1:0]         ld_status;
    logic signed [COORD_W-1:0] ld_x;
    logic signed [COORD_W-1:0] ld_y;
    logic                      ld_last;
    logic                      ld_trunc;

    // Memory access
    logic                      cnt_rd_en;
    logic [CELL_AW-1:0]        cnt_rd_addr;
    logic [CNT_W-1:0]          cnt_rdata;
    logic                      cnt_we;
    logic                      slot_rd_en;
    logic [SLOT_AW-1:0]        slot_rd_addr;
    logic [2*COORD_W-1:0]      slot_rdata;
    logic                      slot_we;
    logic [SLOT_AW-1:0]        slot_wr_addr;
    logic signed [COORD_W-1:0] slot_x;
    logic signed [COORD_W-1:0] slot_y;
    logic                      hit;

    // Setup arithmetic
    logic [DIST_W:0]           cr_q;
    logic signed [SPAN_W-1:0]  cr_eff;
    logic signed [SPAN_W-1:0]  x0, x1, y0, y1, x0c, x1c, y0c, y1c;
    logic                      outside;
    logic [CNT_W-1:0]          cnt_clamp;

    shpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shpd_store #(
        .NCELLS  (NCELLS),
        .NSLOTS  (NSLOTS),
        .CELL_AW (CELL_AW),
        .SLOT_AW (SLOT_AW)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .clr_busy     (clr_busy),
        .cnt_rd_en    (cnt_rd_en),
        .cnt_rd_addr  (cnt_rd_addr),
        .cnt_rdata    (cnt_rdata),
        .cnt_we       (cnt_we),
        .cnt_wr_addr  (own_cell_reg),
        .cnt_wdata    (own_cnt_reg + 1'b1),
        .slot_rd_en   (slot_rd_en),
        .slot_rd_addr (slot_rd_addr),
        .slot_rdata   (slot_rdata),
        .slot_we      (slot_we),
        .slot_wr_addr (slot_wr_addr),
        .slot_wdata   ({px_reg, py_reg})
    );

    assign slot_x = slot_rdata[2*COORD_W-1:COORD_W];
    assign slot_y = slot_rdata[COORD_W-1:0];

    shpd_dist u_dist (
        .clk    (clk),
        .start  (state_reg == S_MUL),
        .pos_x  (px_reg),
        .pos_y  (py_reg),
        .slot_x (slot_x),
        .slot_y (slot_y),
        .thr    (thr_reg),
        .hit    (hit)
    );

    // Handshake and memory ports
    assign in_ch.ready  = (state_reg == S_IDLE) && !clr_busy;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign cnt_rd_en    = (state_reg == S_CELL);
    assign cnt_rd_addr  = CELL_AW'(CELL_AW'(cy_reg) * CELL_AW'(GRID_W) + CELL_AW'(cx_reg));
    assign slot_rd_en   = (state_reg == S_RD);
    assign slot_rd_addr = base_reg + SLOT_AW'(s_reg);
    assign slot_wr_addr = SLOT_AW'(SLOT_AW'(own_cell_reg) * SLOT_AW'(CELL_SLOTS))
                          + SLOT_AW'(own_cnt_reg);
    assign cnt_clamp    = (cnt_rdata > CNT_W'(CELL_SLOTS)) ? CNT_W'(CELL_SLOTS) : cnt_rdata;

    // Cell range around the point, clipped to the grid
    assign cr_q    = ({1'b0, cfg.query_radius} + CELL_ROUND) >> CELL_SHIFT;
    assign cr_eff  = (cmd_reg == CMD_QUERY) ? SPAN_W'(cr_q) : SPAN_W'(nb_reg);
    assign x0      = gx_reg - cr_eff;
    assign x1      = gx_reg + cr_eff;
    assign y0      = gy_reg - cr_eff;
    assign y1      = gy_reg + cr_eff;
    assign x0c     = (x0 < 0) ? '0 : x0;
    assign y0c     = (y0 < 0) ? '0 : y0;
    assign x1c     = (x1 > X_MAX) ? X_MAX : x1;
    assign y1c     = (y1 > Y_MAX) ? Y_MAX : y1;
    assign outside = (gx_reg < 0) || (gx_reg > X_MAX) || (gy_reg < 0) || (gy_reg > Y_MAX);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        nb_next         = nb_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        x_lo_next       = x_lo_reg;
        x_hi_next       = x_hi_reg;
        y_lo_next       = y_lo_reg;
        y_hi_next       = y_hi_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        thr_next        = thr_reg;
        own_cell_next   = own_cell_reg;
        cell_addr_next  = cell_addr_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        s_next          = s_reg;
        own_cnt_next    = own_cnt_reg;
        n_next          = n_reg;
        trunc_next      = trunc_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_trunc_next  = res_trunc_reg;
        cnt_we          = 1'b0;
        slot_we         = 1'b0;
        out_load        = 1'b0;
        ld_status       = res_status_reg;
        ld_x            = res_x_reg;
        ld_y            = res_y_reg;
        ld_last         = 1'b1;
        ld_trunc        = res_trunc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the next command
                if (in_ch.valid && in_ch.ready)
                begin
                    cmd_next   = in_ch.command;
                    nb_next    = in_ch.check_neighbors;
                    px_next    = in_ch.pos_x;
                    py_next    = in_ch.pos_y;
                    state_next = S_GRID;
                end
            end
            S_GRID:
            begin
                // Map the point to grid column and row
                gx_next = ($signed({{(SPAN_W-COORD_W){px_reg[COORD_W-1]}}, px_reg})
                           >>> CELL_SHIFT) - SPAN_W'(cfg.origin_cell_x);
                gy_next = ($signed({{(SPAN_W-COORD_W){py_reg[COORD_W-1]}}, py_reg})
                           >>> CELL_SHIFT) - SPAN_W'(cfg.origin_cell_y);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                x_lo_next       = GX_W'(x0c);
                x_hi_next       = GX_W'(x1c);
                y_lo_next       = GY_W'(y0c);
                y_hi_next       = GY_W'(y1c);
                cx_next         = GX_W'(x0c);
                cy_next         = GY_W'(y0c);
                own_cell_next   = CELL_AW'(CELL_AW'(gy_reg[GY_W-1:0]) * CELL_AW'(GRID_W)
                                  + CELL_AW'(gx_reg[GX_W-1:0]));
                own_cnt_next    = '0;
                n_next          = '0;
                trunc_next      = 1'b0;
                pend_valid_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_trunc_next  = 1'b0;
                if (cmd_reg == CMD_QUERY)
                begin
                    thr_next = cfg.query_radius;
                end
                else if (nb_reg)
                begin
                    thr_next = cfg.neighbor_min_distance;
                end
                else
                begin
                    thr_next = cfg.exact_min_distance;
                end
                priority if ((cmd_reg == CMD_INSERT) && outside)
                begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_RESULT;
                end
                else if ((x0c > x1c) || (y0c > y1c))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                // Read the cell count
                cell_addr_next = cnt_rd_addr;
                state_next     = S_CNT;
            end
            S_CNT:
            begin
                cnt_next  = cnt_clamp;
                s_next    = '0;
                base_next = SLOT_AW'(SLOT_AW'(cell_addr_reg) * SLOT_AW'(CELL_SLOTS));
                if (cell_addr_reg == own_cell_reg)
                begin
                    own_cnt_next = cnt_clamp;
                end
                state_next = (cnt_clamp == '0) ? S_NEXT : S_RD;
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (hit && (cmd_reg == CMD_INSERT))
                begin
                    res_status_next = ST_DUPLICATE;
                    state_next      = S_RESULT;
                end
                else if (hit && (n_reg == N_W'(MAX_MATCHES)))
                begin
                    trunc_next = 1'b1;
                    state_next = S_FINISH;
                end
                else if (hit && pend_valid_reg && !out_free)
                begin
                    // Hold until the previous match drains
                    state_next = S_CMP;
                end
                else
                begin
                    if (hit)
                    begin
                        // Emit the held match, keep this one back for last
                        if (pend_valid_reg)
                        begin
                            out_load  = 1'b1;
                            ld_status = ST_MATCH;
                            ld_x      = pend_x_reg;
                            ld_y      = pend_y_reg;
                            ld_last   = 1'b0;
                            ld_trunc  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = slot_x;
                        pend_y_next     = slot_y;
                        n_next          = n_reg + 1'b1;
                    end
                    if (s_reg + 1'b1 == cnt_reg)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_NEXT:
            begin
                // Advance row first, then column
                if (cy_reg == y_hi_reg)
                begin
                    cy_next = y_lo_reg;
                    if (cx_reg == x_hi_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cx_next    = cx_reg + 1'b1;
                        state_next = S_CELL;
                    end
                end
                else
                begin
                    cy_next    = cy_reg + 1'b1;
                    state_next = S_CELL;
                end
            end
            S_FINISH:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (own_cnt_reg >= CNT_W'(CELL_SLOTS))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        slot_we         = 1'b1;
                        cnt_we          = 1'b1;
                        res_status_next = ST_INSERTED;
                    end
                end
                else if (pend_valid_reg)
                begin
                    res_status_next = ST_MATCH;
                    res_x_next      = pend_x_reg;
                    res_y_next      = pend_y_reg;
                    res_trunc_next  = trunc_reg;
                end
                else
                begin
                    res_status_next = ST_NO_MATCH;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // Hand the final transaction to the output register
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ch.ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
            trunc_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            n_reg          <= n_next;
            trunc_reg      <= trunc_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        nb_reg         <= nb_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        x_lo_reg       <= x_lo_next;
        x_hi_reg       <= x_hi_next;
        y_lo_reg       <= y_lo_next;
        y_hi_reg       <= y_hi_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        thr_reg        <= thr_next;
        own_cell_reg   <= own_cell_next;
        cell_addr_reg  <= cell_addr_next;
        base_reg       <= base_next;
        cnt_reg        <= cnt_next;
        s_reg          <= s_next;
        own_cnt_reg    <= own_cnt_next;
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_trunc_reg  <= res_trunc_next;
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_x_reg      <= ld_x;
            out_y_reg      <= ld_y;
            out_last_reg   <= ld_last;
            out_trunc_reg  <= ld_trunc;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.match_x   = out_x_reg;
    assign out_ch.match_y   = out_y_reg;
    assign out_ch.last      = out_last_reg;
    assign out_ch.truncated = out_trunc_reg;

    `SHPD_ASSERT_IMPL(a_store_room, cnt_we, own_cnt_reg < CNT_W'(CELL_SLOTS), "insert into full cell")
    `SHPD_ASSERT_IMPL(a_match_cap, 1'b1, n_reg <= N_W'(MAX_MATCHES), "match count past cap")
    `SHPD_ASSERT_NEXT(a_accept_start, in_ch.valid && in_ch.ready, state_reg == S_GRID, "accept lost")
    `SHPD_ASSERT_IMPL(a_load_free, out_load, !out_valid_reg || out_ch.ready, "output overwritten")

endmodule

>>> verif/tb_top.sv
module tb_top
    import shpd_pkg::*;
();

    localparam int GRID_W      = 64;
    localparam int GRID_H      = 64;
    localparam int CELL_SLOTS  = 20;
    localparam int CELL_SHIFT  = 9;
    localparam int MAX_MATCHES = 64;
    localparam int CELL_SPAN   = 1 << CELL_SHIFT;

    typedef struct {
        logic [STAT_W-1:0]         status;
        logic signed [COORD_W-1:0] match_x;
        logic signed [COORD_W-1:0] match_y;
        logic                      last;
        logic                      truncated;
    } dedup_result_t;

    // Grid store predictor and queue of expected result transactions
    class point_grid_model;
        longint          neighbor_min;
        longint          exact_min;
        longint          radius;
        longint          origin_x;
        longint          origin_y;
        int              cell_fill [GRID_W*GRID_H];
        logic [39:0]     slot_point [GRID_W*GRID_H*CELL_SLOTS];
        dedup_result_t   expected_results [$];
        int              errors;

        function new();
            neighbor_min = 128;
            exact_min    = 26;
            radius       = 512;
            origin_x     = 0;
            origin_y     = 0;
            errors       = 0;
            foreach (cell_fill[i])
                cell_fill[i] = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_NEIGHBOR_MIN: neighbor_min = val;
                REG_EXACT_MIN:    exact_min = val;
                REG_QUERY_RADIUS: radius = val;
                REG_ORIGIN_X:     origin_x = longint'(signed'(val));
                REG_ORIGIN_Y:     origin_y = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void slot_xy(int idx, output longint sx, output longint sy);
            logic signed [COORD_W-1:0] hx;
            logic signed [COORD_W-1:0] hy;
            hx = slot_point[idx][39:20];
            hy = slot_point[idx][19:0];
            sx = hx;
            sy = hy;
        endfunction

        // Scan one cell for a stored point strictly inside thr; off-grid cells are empty
        function bit cell_close(longint gx, longint gy, longint px, longint py, longint thr);
            int     cell_idx;
            longint sx;
            longint sy;
            if (gx < 0 || gx >= GRID_W || gy < 0 || gy >= GRID_H)
                return 0;
            cell_idx = int'(gy) * GRID_W + int'(gx);
            for (int s = 0; s < cell_fill[cell_idx]; s++)
            begin
                slot_xy(cell_idx * CELL_SLOTS + s, sx, sy);
                if ((px-sx)*(px-sx) + (py-sy)*(py-sy) < thr*thr)
                    return 1;
            end
            return 0;
        endfunction

        function void push(logic [STAT_W-1:0] st, longint x, longint y, logic l, logic t);
            dedup_result_t r;
            r.status    = st;
            r.match_x   = x[COORD_W-1:0];
            r.match_y   = y[COORD_W-1:0];
            r.last      = l;
            r.truncated = t;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void accept_command(logic cmd, logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y, logic nb);
            longint px;
            longint py;
            longint gx;
            longint gy;
            longint cr;
            longint x0;
            longint x1;
            longint y0;
            longint y1;
            longint sx;
            longint sy;
            int     cell_idx;
            int     n;
            bit     dup;
            bit     trunc;
            px = x;
            py = y;
            gx = (px >>> CELL_SHIFT) - origin_x;
            gy = (py >>> CELL_SHIFT) - origin_y;
            if (cmd == CMD_INSERT)
            begin
                if (gx < 0 || gx >= GRID_W || gy < 0 || gy >= GRID_H)
                begin
                    push(ST_OUTSIDE, 0, 0, 1, 0);
                    return;
                end
                dup = 0;
                if (!nb)
                    dup = cell_close(gx, gy, px, py, exact_min);
                else
                    for (int dx = -1; dx <= 1; dx++)
                        for (int dy = -1; dy <= 1; dy++)
                            if (cell_close(gx+dx, gy+dy, px, py, neighbor_min))
                                dup = 1;
                cell_idx = int'(gy) * GRID_W + int'(gx);
                if (dup)
                    push(ST_DUPLICATE, 0, 0, 1, 0);
                else if (cell_fill[cell_idx] >= CELL_SLOTS)
                    push(ST_FULL, 0, 0, 1, 0);
                else
                begin
                    slot_point[cell_idx * CELL_SLOTS + cell_fill[cell_idx]] = {x, y};
                    cell_fill[cell_idx]++;
                    push(ST_INSERTED, 0, 0, 1, 0);
                end
                return;
            end
            // Radius query over the clipped cell window
            cr = (radius + CELL_SPAN - 1) >> CELL_SHIFT;
            x0 = (gx - cr < 0) ? 0 : gx - cr;
            y0 = (gy - cr < 0) ? 0 : gy - cr;
            x1 = (gx + cr > GRID_W-1) ? GRID_W-1 : gx + cr;
            y1 = (gy + cr > GRID_H-1) ? GRID_H-1 : gy + cr;
            n = 0;
            trunc = 0;
            for (longint cx = x0; cx <= x1 && !trunc; cx++)
                for (longint cy = y0; cy <= y1 && !trunc; cy++)
                begin
                    cell_idx = int'(cy) * GRID_W + int'(cx);
                    for (int s = 0; s < cell_fill[cell_idx] && !trunc; s++)
                    begin
                        slot_xy(cell_idx * CELL_SLOTS + s, sx, sy);
                        if ((px-sx)*(px-sx) + (py-sy)*(py-sy) < radius*radius)
                        begin
                            if (n >= MAX_MATCHES)
                                trunc = 1;
                            else
                            begin
                                push(ST_MATCH, sx, sy, 0, 0);
                                n++;
                            end
                        end
                    end
                end
            if (n == 0)
                push(ST_NO_MATCH, 0, 0, 1, 0);
            else
            begin
                expected_results[$].last      = 1;
                expected_results[$].truncated = trunc;
            end
        endfunction

        function void check_result(dedup_result_t got);
            dedup_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction, status %0d", got.status);
                errors++;
                return;
            end
            exp_r = expected_results[0];
            expected_results.delete(0);
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.match_x !== exp_r.match_x)
            begin
                $error("match_x: expected %0d, got %0d", exp_r.match_x, got.match_x);
                errors++;
            end
            if (got.match_y !== exp_r.match_y)
            begin
                $error("match_y: expected %0d, got %0d", exp_r.match_y, got.match_y);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
            if (got.truncated !== exp_r.truncated)
            begin
                $error("truncated: expected %0d, got %0d", exp_r.truncated, got.truncated);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    shpd_in_if  in_ch ();
    shpd_out_if out_ch ();

    spatial_hash_point_dedup DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    point_grid_model grid_model = new();
    int              burst_left = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Write one register with a setup and an access phase
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        grid_model.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Offer one command in bursts with random gaps, and hold until accepted
    task automatic send_command(logic cmd, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y, logic nb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= cmd;
        in_ch.pos_x           <= x;
        in_ch.pos_y           <= y;
        in_ch.check_neighbors <= nb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        grid_model.accept_command(cmd, x, y, nb);
        burst_left--;
    endtask

    // Drop valid and wait for all results, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (grid_model.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random commands: mostly inside a window of cells, some full-range noise
    task automatic send_random(int count, int base_cx, int base_cy, int span, int query_pct,
                               int nb_pct);
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 99) < query_pct) ? CMD_QUERY : CMD_INSERT;
            if ($urandom_range(0, 99) < 12)
            begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            else
            begin
                x = COORD_W'(base_cx * CELL_SPAN + int'($urandom_range(0, span*CELL_SPAN-1)));
                y = COORD_W'(base_cy * CELL_SPAN + int'($urandom_range(0, span*CELL_SPAN-1)));
            end
            send_command(cmd, x, y, ($urandom_range(0, 99) < nb_pct));
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.command         <= CMD_INSERT;
        in_ch.pos_x           <= '0;
        in_ch.pos_y           <= '0;
        in_ch.check_neighbors <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // hold until the count sweep after reset is done
        do
            @(posedge clk);
        while (!in_ch.ready);

        // Directed: defaults, thresholds, grid edges
        send_command(CMD_INSERT, 0, 0, 0);
        send_command(CMD_INSERT, 10, 0, 0);
        send_command(CMD_INSERT, 26, 0, 0);
        send_command(CMD_INSERT, 600, 0, 1);
        send_command(CMD_INSERT, 520, 0, 1);
        send_command(CMD_INSERT, -1, 0, 0);
        send_command(CMD_INSERT, 524287, 524287, 1);
        send_command(CMD_INSERT, -524288, -524288, 0);
        send_command(CMD_INSERT, 32767, 32767, 0);
        send_command(CMD_INSERT, 32767-100, 32767, 1);
        send_command(CMD_QUERY, 0, 0, 0);
        send_command(CMD_QUERY, 100000, 100000, 0);
        send_command(CMD_QUERY, 32767, 32767, 1);
        send_command(CMD_QUERY, -524288, 524287, 0);
        send_command(CMD_QUERY, -300, -300, 0);
        drain();

        // Dense cluster: full cells and truncated queries
        write_reg(REG_NEIGHBOR_MIN, 16'd300);
        write_reg(REG_EXACT_MIN, 16'd1);
        write_reg(REG_QUERY_RADIUS, 16'd2000);
        send_random(130, 2, 2, 2, 20, 20);
        drain();

        // Extremes: origin pushes every point off the grid
        write_reg(REG_NEIGHBOR_MIN, 16'd0);
        write_reg(REG_EXACT_MIN, 16'hFFFF);
        write_reg(REG_QUERY_RADIUS, 16'd0);
        write_reg(REG_ORIGIN_X, 16'h8000);
        write_reg(REG_ORIGIN_Y, 16'h7FFF);
        send_random(15, 0, 0, 4, 40, 50);
        drain();

        // Grid at the coordinate corner, huge/zero thresholds, few full-grid queries
        write_reg(REG_NEIGHBOR_MIN, 16'hFFFF);
        write_reg(REG_EXACT_MIN, 16'd0);
        write_reg(REG_ORIGIN_X, 16'hFC00);
        write_reg(REG_ORIGIN_Y, 16'd960);
        send_random(30, -1024, 1018, 5, 0, 30);
        drain();
        write_reg(REG_QUERY_RADIUS, 16'hFFFF);
        send_random(4, -1024, 1018, 5, 100, 0);
        drain();

        // Mid settings around a negative origin
        write_reg(REG_NEIGHBOR_MIN, 16'd128);
        write_reg(REG_EXACT_MIN, 16'd26);
        write_reg(REG_QUERY_RADIUS, 16'd700);
        write_reg(REG_ORIGIN_X, 16'hFFFD);
        write_reg(REG_ORIGIN_Y, 16'hFFFD);
        send_random(90, -3, -3, 6, 30, 50);
        drain();

        if (grid_model.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result receiver: stall pattern plus one long hold-off
    initial
    begin
        int seen;
        int hold;
        int mode;
        bit held;
        seen = 0;
        hold = 0;
        mode = 0;
        held = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                seen++;
            if (!held && seen >= 40)
            begin
                held = 1;
                hold = 3000;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                out_ch.ready <= 1'b1;
            else if (mode == 1)
                out_ch.ready <= $urandom_range(0, 1);
            else
                out_ch.ready <= ($urandom_range(0, 7) == 0);
        end
    end

    // Check each accepted result transaction
    always @(posedge clk)
    begin
        dedup_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.status    = out_ch.status;
            got.match_x   = out_ch.match_x;
            got.match_y   = out_ch.match_y;
            got.last      = out_ch.last;
            got.truncated = out_ch.truncated;
            grid_model.check_result(got);
        end
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
